>>> src/met_pkg.sv
`default_nettype none
package met_pkg;

  // fixed-point format and screen size
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MAX_DIM   = 4096;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COORD_MAX = (MAX_DIM - 1 > 4095) ? 4095 : MAX_DIM - 1;
  localparam int unsigned ITER_W    = 16;

  // |z|^2 >= 4, scaled by 2^(2*frac)
  localparam logic [63:0] ESC_BOUND = 64'(1) << (2 * FRAC_BITS + 2);

  // register file indexes
  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_RE   = 3'd2;
  localparam logic [2:0] REG_STEP_IM   = 3'd3;
  localparam logic [2:0] REG_ITER_LIM  = 3'd4;
  localparam logic [2:0] REG_POWER     = 3'd5;

  // reset values
  localparam logic [31:0] RST_ORIGIN_RE = 32'hDCCCCCCD;
  localparam logic [31:0] RST_ORIGIN_IM = 32'hE4CCCCCD;
  localparam logic [30:0] RST_STEP      = 31'd760567;
  localparam logic [15:0] RST_ITER_LIM  = 16'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_CSET,
    ST_SQ,
    ST_TEST,
    ST_CUBE,
    ST_CUPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_COORD,
    MUL_SQ,
    MUL_CUBE
  } mul_sel_t;

  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_c;
    logic     set_t;
    logic     upd_z;
    logic     upd_cube;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> src/mandelbrot_escape_time.sv
`default_nettype none
// channel | dir | beat contents (lsb first)              | handshake
// in_     | in  | tdata: column[11:0], row[23:12]        | in_tvalid / in_tready
// out_    | out | tdata: iterations[15:0]                | out_tvalid / out_tready
// cfg_    | in  | apb regs at 4*i: origin_re, origin_im, | psel, penable, pready
//         |     | step_re, step_im, iteration_limit,     |
//         |     | power_mode                             |
//
// one pixel at a time; the shared bank of four 32x32 multipliers with
// registered products sets the pace: each z^2 + c iteration runs the square
// and test states, each z^3 + c iteration adds the cube and update states;
// coordinate map, setup, final test and hand-off lie between accept and
// result, and the engine goes back to idle to take the next pixel
// synchronous active-low reset returns the registers to their defaults and
// empties the output slot
// a finished count sits in the output register; the next pixel is taken while
// it waits, and the engine only holds at the end of that pixel if it is not taken
module mandelbrot_escape_time
  import met_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // pixel input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,     // column[11:0], row[23:12]
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // iterations[15:0]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // register file
  logic signed [31:0] origin_re_r, origin_im_r;
  logic [30:0]        step_re_r, step_im_r;
  logic [15:0]        iter_lim_r;
  logic               power_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= RST_ORIGIN_RE;
      origin_im_r <= RST_ORIGIN_IM;
      step_re_r   <= RST_STEP;
      step_im_r   <= RST_STEP;
      iter_lim_r  <= RST_ITER_LIM;
      power_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_RE: origin_re_r <= cfg_pwdata;
        REG_ORIGIN_IM: origin_im_r <= cfg_pwdata;
        REG_STEP_RE:   step_re_r   <= cfg_pwdata[30:0];
        REG_STEP_IM:   step_im_r   <= cfg_pwdata[30:0];
        REG_ITER_LIM:  iter_lim_r  <= cfg_pwdata[15:0];
        REG_POWER:     power_r     <= cfg_pwdata[0];
        default:       ;  // unmapped, write dropped
      endcase
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_RE: cfg_prdata = origin_re_r;
      REG_ORIGIN_IM: cfg_prdata = origin_im_r;
      REG_STEP_RE:   cfg_prdata = {1'b0, step_re_r};
      REG_STEP_IM:   cfg_prdata = {1'b0, step_im_r};
      REG_ITER_LIM:  cfg_prdata = {16'd0, iter_lim_r};
      REG_POWER:     cfg_prdata = {31'd0, power_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // controller and datapath talk only through cmd / status
  cmd_t    cmd;
  status_t status;

  met_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .power_mode (power_r),
    .status     (status),
    .in_ready   (in_tready),
    .cmd        (cmd)
  );

  met_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .column         (in_tdata[11:0]),
    .row            (in_tdata[23:12]),
    .origin_re      (origin_re_r),
    .origin_im      (origin_im_r),
    .step_re        (step_re_r),
    .step_im        (step_im_r),
    .iter_limit     (iter_lim_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_iterations (out_tdata)
  );

endmodule
`default_nettype wire

>>> src/met_ctrl.sv
`default_nettype none
module met_ctrl
  import met_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    power_mode,
  input  wire status_t status,
  output logic         in_ready,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_COORD;
      end
      ST_COORD: state_nxt = ST_CSET;
      ST_CSET:  state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_TEST;
      ST_TEST: begin
        if (status.escaped || status.at_limit) state_nxt = ST_DONE;
        else if (power_mode)                  state_nxt = ST_CUBE;
        else                                  state_nxt = ST_SQ;
      end
      ST_CUBE:  state_nxt = ST_CUPD;
      ST_CUPD:  state_nxt = ST_SQ;
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SQ;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_COORD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COORD;
      end
      ST_CSET:  cmd.load_c = 1'b1;
      ST_SQ:    cmd.mul_en = 1'b1;
      ST_TEST: begin
        if (!status.escaped && !status.at_limit) begin
          if (power_mode) cmd.set_t = 1'b1;
          else            cmd.upd_z = 1'b1;
        end
      end
      ST_CUBE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CUBE;
      end
      ST_CUPD: begin
        cmd.upd_z    = 1'b1;
        cmd.upd_cube = 1'b1;
      end
      ST_DONE:  cmd.load_out = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/met_dp.sv
`default_nettype none
module met_dp
  import met_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [COORD_W-1:0] column,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic signed [31:0] origin_re,
  input  wire logic signed [31:0] origin_im,
  input  wire logic [30:0]        step_re,
  input  wire logic [30:0]        step_im,
  input  wire logic [ITER_W-1:0]  iter_limit,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ITER_W-1:0]       out_iterations
);

  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483647;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI)      r = SAT_HI[31:0];
    else if (x < SAT_LO) r = SAT_LO[31:0];
    else                 r = x[31:0];
    return r;
  endfunction

  logic [COORD_W-1:0] col_r, row_r;
  logic signed [31:0] c_re_r, c_im_r, re_r, im_r, t_re_r, t_im_r;
  logic signed [63:0] p_r [4];
  logic [ITER_W-1:0]  iter_r;
  logic               out_valid_r;
  logic [ITER_W-1:0]  out_iter_r;

  logic signed [31:0] op_a [4];
  logic signed [31:0] op_b [4];
  logic signed [64:0] pw [4];
  logic signed [64:0] sh_re, sh_im_sq, sh_im_cu, sh_im;
  logic signed [64:0] nre_w, nim_w, cre_w, cim_w;
  logic [63:0]        mag_w;

  // operand selection for the shared multiplier bank
  always_comb begin
    op_a[0] = re_r;   op_b[0] = re_r;
    op_a[1] = im_r;   op_b[1] = im_r;
    op_a[2] = re_r;   op_b[2] = im_r;
    op_a[3] = im_r;   op_b[3] = re_r;
    case (cmd.mul_sel)
      MUL_COORD: begin
        op_a[0] = $signed({20'd0, col_r});  op_b[0] = $signed({1'b0, step_re});
        op_a[1] = $signed({20'd0, row_r});  op_b[1] = $signed({1'b0, step_im});
      end
      MUL_CUBE: begin
        op_a[0] = t_re_r;  op_b[0] = re_r;
        op_a[1] = t_im_r;  op_b[1] = im_r;
        op_a[2] = t_re_r;  op_b[2] = im_r;
        op_a[3] = t_im_r;  op_b[3] = re_r;
      end
      default: begin
        op_a[0] = re_r;   op_b[0] = re_r;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pw[i] = {p_r[i][63], p_r[i]};
    end
    sh_re    = (pw[0] - pw[1]) >>> FRAC_BITS;
    sh_im_sq = pw[2] >>> (FRAC_BITS - 1);
    sh_im_cu = (pw[2] + pw[3]) >>> FRAC_BITS;
    sh_im    = cmd.upd_cube ? sh_im_cu : sh_im_sq;
    nre_w    = sh_re + {{33{c_re_r[31]}}, c_re_r};
    nim_w    = sh_im + {{33{c_im_r[31]}}, c_im_r};
    cre_w    = pw[0] + {{33{origin_re[31]}}, origin_re};
    cim_w    = pw[1] + {{33{origin_im[31]}}, origin_im};
    mag_w    = $unsigned(p_r[0]) + $unsigned(p_r[1]);
  end

  assign status.escaped  = (mag_w >= ESC_BOUND);
  assign status.at_limit = (iter_r >= iter_limit);
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      col_r <= (column > COORD_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : column;
      row_r <= (row > COORD_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : row;
    end
    if (cmd.mul_en) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= op_a[i] * op_b[i];
      end
    end
    if (cmd.load_c) begin
      c_re_r <= sat32(cre_w);
      c_im_r <= sat32(cim_w);
      re_r   <= '0;
      im_r   <= '0;
      iter_r <= '0;
    end
    if (cmd.set_t) begin
      t_re_r <= sat32(sh_re);
      t_im_r <= sat32(sh_im_sq);
    end
    if (cmd.upd_z) begin
      re_r   <= sat32(nre_w);
      im_r   <= sat32(nim_w);
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_iter_r <= iter_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iterations = out_iter_r;

endmodule
`default_nettype wire

>>> tb/mandelbrot_escape_time_test.sv
`timescale 1ns / 100ps

module mandelbrot_escape_time_test;
  import met_pkg::*;

  // register slots past the last real one, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // |z|^2 bound of 4 at doubled fraction width, and the symmetric clip level
  localparam longint ESCAPE_SQ = longint'(4) << (2 * FRAC_BITS);
  localparam longint CLIP_MAX  = 64'sd2147483647;

  localparam int PIX_PER_PHASE  = 40;
  localparam int RANDOM_PHASES  = 30;
  localparam int RX_HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // column[11:0], row[23:12]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // iterations[15:0]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mandelbrot_escape_time DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow copy of the register file, starts at the reset values
  logic signed [31:0] org_re    = RST_ORIGIN_RE;
  logic signed [31:0] org_im    = RST_ORIGIN_IM;
  logic [30:0]        stp_re    = RST_STEP;
  logic [30:0]        stp_im    = RST_STEP;
  logic [15:0]        iter_lim  = RST_ITER_LIM;
  logic               cube_mode = 1'b0;

  pixel_t      pixel_q[$];        // pixels waiting to be driven
  logic [15:0] iter_expect[$];    // predicted counts, oldest first
  int          items_queued = 0;
  int          items_accepted = 0;
  int          fail_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic        beat_taken = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  pixel_t      next_px;

  initial forever #10 clk = ~clk;

  // generous fixed time ceiling for the whole run
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // escape-time predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip_q(longint x);
    if (x > CLIP_MAX)
      return CLIP_MAX;
    if (x < -CLIP_MAX)
      return -CLIP_MAX;
    return x;
  endfunction

  function automatic logic [15:0] escape_count(logic [11:0] col, logic [11:0] row);
    longint      cr, ci, zr, zi, sr, si, tr, ti, nr, ni;
    int unsigned n;
    // a 12-bit coordinate never passes the screen edge at this size, clamp anyway
    if (col > MAX_DIM - 1)
      col = 12'(MAX_DIM - 1);
    if (row > MAX_DIM - 1)
      row = 12'(MAX_DIM - 1);
    cr = clip_q(longint'(org_re) + longint'(col) * longint'(stp_re));
    ci = clip_q(longint'(org_im) + longint'(row) * longint'(stp_im));
    zr = 0;
    zi = 0;
    n = 0;
    // products of clipped values stay below 2^63, so longint holds them exactly
    while (zr * zr + zi * zi < ESCAPE_SQ && n < iter_lim) begin
      sr = (zr * zr - zi * zi) >>> FRAC_BITS;
      si = (zr * zi) >>> (FRAC_BITS - 1);
      if (cube_mode) begin
        // z^2 is clipped on its own before the third multiply
        tr = clip_q(sr);
        ti = clip_q(si);
        nr = clip_q(((tr * zr - ti * zi) >>> FRAC_BITS) + cr);
        ni = clip_q(((tr * zi + ti * zr) >>> FRAC_BITS) + ci);
      end else begin
        nr = clip_q(sr + cr);
        ni = clip_q(si + ci);
      end
      zr = nr;
      zi = ni;
      n++;
    end
    return n[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: new beat at the falling edge, handshake seen at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      // config is frozen while pixels are in flight, so predict at acceptance
      iter_expect.push_back(escape_count(in_tdata[11:0], in_tdata[23:12]));
      items_accepted++;
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_taken)) begin
      beat_taken = 1'b0;
      if (pixel_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        next_px = pixel_q.pop_front();
        in_tdata <= {next_px.row, next_px.col};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  // ready side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = RX_HOLD_CYCLES;
    end
    out_tready <= rst_n && hold_left == 0 && $urandom_range(99) >= rcv_idle_pct;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (iter_expect.size() == 0) begin
        $error("iterations: expected nothing, got %0d", out_tdata);
        fail_count++;
      end else if (out_tdata !== iter_expect[0]) begin
        $error("iterations: expected %0d, got %0d", iter_expect[0], out_tdata);
        fail_count++;
        void'(iter_expect.pop_front());
      end else begin
        void'(iter_expect.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_px(logic [11:0] col, logic [11:0] row);
    pixel_q.push_back('{row: row, col: col});
    items_queued++;
  endtask

  // sender pause: nothing queued, nothing in flight
  task automatic drain();
    while (items_accepted != items_queued || iter_expect.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    case (idx)
      REG_ORIGIN_RE: org_re = val;
      REG_ORIGIN_IM: org_im = val;
      REG_STEP_RE:   stp_re = val[30:0];
      REG_STEP_IM:   stp_im = val[30:0];
      REG_ITER_LIM:  iter_lim = val[15:0];
      REG_POWER:     cube_mode = val[0];
      default: ;     // spare slots are ignored
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_check(logic [2:0] idx);
    logic [31:0] want;
    case (idx)
      REG_ORIGIN_RE: want = org_re;
      REG_ORIGIN_IM: want = org_im;
      REG_STEP_RE:   want = {1'b0, stp_re};
      REG_STEP_IM:   want = {1'b0, stp_im};
      REG_ITER_LIM:  want = {16'h0, iter_lim};
      default:       want = {31'h0, cube_mode};
    endcase
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready)
      @(posedge clk);
    if (cfg_prdata !== want) begin
      $error("register %0d readback: expected %h, got %h", idx, want, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // full reprogram of the window, then read every register back
  task automatic set_window(logic [31:0] o_re, logic [31:0] o_im, logic [31:0] s_re,
                            logic [31:0] s_im, logic [15:0] lim, logic pwr);
    cfg_write(REG_ORIGIN_RE, o_re);
    cfg_write(REG_ORIGIN_IM, o_im);
    cfg_write(REG_STEP_RE, s_re);
    cfg_write(REG_STEP_IM, s_im);
    cfg_write(REG_ITER_LIM, {16'h0, lim});
    cfg_write(REG_POWER, {31'h0, pwr});
    for (int r = REG_ORIGIN_RE; r <= REG_POWER; r++)
      cfg_check(r[2:0]);
  endtask

  initial begin
    logic [31:0] o_re, o_im, s_re, s_im;
    logic [15:0] lim;
    logic        pwr;
    int          kind;

    snd_idle_pct = 32;
    rcv_idle_pct = 62;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: the classic window at 500 iterations, z^2 + c
    for (int r = REG_ORIGIN_RE; r <= REG_POWER; r++)
      cfg_check(r[2:0]);
    add_px(12'd0, 12'd0);
    add_px(12'hFFF, 12'd0);
    add_px(12'd0, 12'hFFF);
    add_px(12'hFFF, 12'hFFF);
    add_px(12'hAAA, 12'h555);
    add_px(12'h555, 12'hAAA);
    add_px(12'd777, 12'd600);   // c near zero, runs to the limit
    add_px(12'd600, 12'd600);   // c near -0.5, main cardioid
    add_px(12'd400, 12'd600);   // c near -1, period-two bulb
    add_px(12'd640, 12'd860);
    drain();

    // same window, cube mode
    cfg_write(REG_POWER, 32'd1);
    add_px(12'd777, 12'd600);
    add_px(12'd600, 12'd600);
    add_px(12'd0, 12'd0);
    add_px(12'hFFF, 12'hFFF);
    add_px(12'd700, 12'd700);
    drain();

    // zero limit gives a zero count even for an inside point
    cfg_write(REG_ITER_LIM, 32'd0);
    add_px(12'd777, 12'd600);
    add_px(12'hFFF, 12'd0);
    drain();

    // register extremes: c saturates on both axes, escapes after one step
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 16'hFFFF, 1'b0);
    add_px(12'd0, 12'd0);
    add_px(12'hFFF, 12'hFFF);
    drain();

    // c = 0 never escapes: the full 16-bit count comes back
    set_window(32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF, 1'b0);
    add_px(12'd5, 12'd5);
    drain();

    // writes to the spare slots must leave the window untouched
    set_window(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    cfg_write(REG_SPARE_LO, 32'h0000_0000);
    cfg_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    for (int r = REG_ORIGIN_RE; r <= REG_POWER; r++)
      cfg_check(r[2:0]);
    add_px(12'hFFF, 12'hFFF);
    drain();

    // random part: one fresh window per phase, idling pattern changes by thirds
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      snd_idle_pct = (ph < RANDOM_PHASES / 3) ? 32 : (ph < 2 * RANDOM_PHASES / 3) ? 62 : 0;
      rcv_idle_pct = (ph < RANDOM_PHASES / 3) ? 62 : (ph < 2 * RANDOM_PHASES / 3) ? 32 : 0;
      kind = $urandom_range(9);
      if (kind == 0) begin
        // anything goes: mostly saturated points that escape at once
        o_re = $urandom();
        o_im = $urandom();
        s_re = $urandom();
        s_im = $urandom();
        lim = 16'($urandom_range(24));
        pwr = 1'($urandom_range(1));
      end else begin
        // window around the set: re in [-2.5, 0.5], im in [-1.5, 1.5], span up to 4
        o_re = $urandom_range(32'd805306368) - 32'd671088640;
        o_im = $urandom_range(32'd805306368) - 32'd402653184;
        s_re = $urandom_range(32'd262144);
        s_im = $urandom_range(32'd262144);
        lim = (kind == 1) ? 16'($urandom_range(200, 100)) : 16'($urandom_range(48, 1));
        pwr = (kind == 1) ? 1'b0 : 1'($urandom_range(1));
      end
      set_window(o_re, o_im, s_re, s_im, lim, pwr);
      for (int i = 0; i < PIX_PER_PHASE; i++)
        add_px(12'($urandom_range(4095)), 12'($urandom_range(4095)));
      // one long back-pressure stretch so the engine fills and stalls its input
      if (ph == 3) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
